// ----- src/tce_pkg.sv -----
package tce_pkg;

   localparam int CENTER_W    = 6;
   localparam int JUMP_W      = 6;
   localparam int MINRUN_W    = 7;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 7;
   localparam int RSP_TDATA_W = 8;

   localparam logic [CENTER_W-1:0]  CENTER_MAX     = 6'd63;
   localparam logic [CSR_IDX_W-1:0] REG_JUMP_LIMIT = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_RUN    = 1'd1;

   localparam logic [JUMP_W-1:0]   JUMP_RESET   = 6'd3;
   localparam logic [MINRUN_W-1:0] MINRUN_RESET = 7'd2;

   // held-row bookkeeping
   localparam logic [1:0] SEEN_NONE  = 2'd0;
   localparam logic [1:0] SEEN_FIRST = 2'd1;
   localparam logic [1:0] SEEN_MID   = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CENTER,
      ST_COMMIT
   } tce_state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic calc;
      logic commit;
   } tce_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic queue_empty;
   } tce_status_type;

   typedef struct packed {
      logic [CENTER_W-1:0] center;
      logic                frame_end;
   } tce_result_type;

   function automatic logic [CENTER_W-1:0] absdiff(input logic [CENTER_W-1:0] a,
                                                    input logic [CENTER_W-1:0] b);
      return (a >= b) ? (a - b) : (b - a);
   endfunction

endpackage

// ----- src/tce_ctrl.sv -----
module tce_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  tce_pkg::tce_status_type status,
   output tce_pkg::tce_cmd_type    cmd
);
   import tce_pkg::*;

   tce_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (status.scan_done) state_in = ST_CENTER;
         end
         ST_CENTER: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            // wait until both result slots are free
            if (status.queue_empty) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_SCAN: begin
            cmd.step = !status.scan_done;
         end
         ST_CENTER: begin
            cmd.calc = 1'b1;
         end
         ST_COMMIT: begin
            cmd.commit = status.queue_empty;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

endmodule

// ----- src/tce_dp.sv -----
module tce_dp #(
   parameter int ROW_WIDTH = 32,
   parameter int TDATA_W   = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [TDATA_W-1:0]                  req_tdata,
   input  logic                                req_tlast,
   input  logic                                csr_we,
   input  logic [tce_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tce_pkg::CSR_DATA_W-1:0]      csr_wdata,
   input  tce_pkg::tce_cmd_type                cmd,
   output logic                                scan_done,
   output logic                                push0,
   output logic                                push1,
   output tce_pkg::tce_result_type             res0,
   output tce_pkg::tce_result_type             res1
);
   import tce_pkg::*;

   localparam int IW = $clog2(ROW_WIDTH);
   localparam int JW = $clog2(ROW_WIDTH + 1);
   localparam int CW = $clog2(2 * ROW_WIDTH + 1);
   localparam int SW = CW + 2;
   localparam int KW = (CW > MINRUN_W) ? CW : MINRUN_W;

   // configuration
   logic [JUMP_W-1:0]   jump_ff, jump_in;
   logic [MINRUN_W-1:0] minr_ff, minr_in;

   // scan state
   logic [ROW_WIDTH-1:0] row_ff, row_in;
   logic [JW-1:0]        j_ff, j_in;
   logic [CW-1:0]        blk_ff, blk_in;
   logic [CW-1:0]        run_ff, run_in;
   logic [CW-1:0]        tot_ff, tot_in;
   logic [CW-1:0]        wht_ff, wht_in;
   logic signed [SW-1:0] whites_ff, whites_in;
   logic                 bfirst_ff, bfirst_in;
   logic                 done_ff, done_in;
   logic                 last_ff, last_in;
   logic [CENTER_W-1:0]  raw_ff, raw_in;

   // row-to-row state
   logic [CENTER_W-1:0] prior_ff, prior_in;
   logic [CENTER_W-1:0] held_ff, held_in;
   logic [1:0]          seen_ff, seen_in;

   logic                 px;
   logic [CW-1:0]        blk_inc, wht_inc;
   logic                 blk_ok, wht_ok, blk_now_ok, run_ok, brk;
   logic [JW-1:0]        j_next;
   logic signed [SW-1:0] csum;
   logic [CENTER_W-1:0]  cur, fin;
   logic [CENTER_W:0]    pair_sum;

   assign px         = row_ff[j_ff[IW-1:0]];
   assign blk_inc    = blk_ff + 1'b1;
   assign wht_inc    = wht_ff + 1'b1;
   assign blk_ok     = KW'(blk_inc) >= KW'(minr_ff);
   assign blk_now_ok = KW'(blk_ff) >= KW'(minr_ff);
   assign wht_ok     = KW'(wht_inc) >= KW'(minr_ff);
   assign run_ok     = KW'(run_ff) >= KW'(minr_ff);
   assign scan_done  = done_ff;

   // one pixel per step
   always_comb begin
      row_in    = row_ff;
      j_in      = j_ff;
      blk_in    = blk_ff;
      run_in    = run_ff;
      tot_in    = tot_ff;
      wht_in    = wht_ff;
      whites_in = whites_ff;
      bfirst_in = bfirst_ff;
      done_in   = done_ff;
      last_in   = last_ff;
      brk       = 1'b0;
      j_next    = j_ff + 1'b1;
      if (cmd.load) begin
         row_in    = req_tdata[ROW_WIDTH-1:0];
         bfirst_in = req_tdata[0];
         last_in   = req_tlast;
         j_in      = '0;
         blk_in    = '0;
         run_in    = '0;
         tot_in    = '0;
         wht_in    = '0;
         whites_in = '0;
         done_in   = 1'b0;
      end else if (cmd.step) begin
         if (!bfirst_ff) begin
            if (!px) begin
               blk_in = '0;
               if (tot_ff != '0 && run_ok) begin
                  whites_in = whites_ff + $signed(SW'(tot_ff)) - $signed(SW'(run_ff));
                  brk       = 1'b1;
               end else begin
                  whites_in = whites_ff + SW'(1);
               end
            end else begin
               blk_in = blk_inc;
               tot_in = tot_ff + 1'b1;
               if (blk_ok) run_in = blk_inc;
            end
         end else begin
            if (px) begin
               blk_in = blk_inc;
               if (blk_ok) run_in = blk_inc;
            end else begin
               wht_in = wht_inc;
               if (wht_ok && blk_now_ok) begin
                  brk = 1'b1;
               end else if (wht_ok) begin
                  // restart once in white-first mode, back over the white pixels
                  bfirst_in = 1'b0;
                  whites_in = SW'(1);
                  j_next    = JW'(CW'(j_ff) - wht_inc + 1'b1);
               end
            end
         end
         j_in    = j_next;
         done_in = brk || (j_next == JW'(ROW_WIDTH));
      end
   end

   // saturated raw center
   assign csum = whites_ff + $signed(SW'(run_ff >> 1));

   always_comb begin
      raw_in = raw_ff;
      if (cmd.calc) begin
         if (csum < 0) begin
            raw_in = '0;
         end else if (csum > $signed(SW'(CENTER_MAX))) begin
            raw_in = CENTER_MAX;
         end else begin
            raw_in = csum[CENTER_W-1:0];
         end
      end
   end

   // outlier correction
   assign pair_sum = {1'b0, prior_ff} + {1'b0, raw_ff};

   always_comb begin
      cur = held_ff;
      if (seen_ff != SEEN_FIRST && absdiff(held_ff, prior_ff) >= jump_ff) begin
         if (absdiff(prior_ff, raw_ff) >= jump_ff) begin
            cur = prior_ff;
         end else begin
            cur = pair_sum[CENTER_W:1];
         end
      end
      fin = (absdiff(raw_ff, cur) >= jump_ff) ? cur : raw_ff;
   end

   always_comb begin
      prior_in = prior_ff;
      held_in  = held_ff;
      seen_in  = seen_ff;
      push0    = 1'b0;
      push1    = 1'b0;
      res0     = '{center: cur, frame_end: 1'b0};
      res1     = '{center: fin, frame_end: 1'b1};
      if (cmd.commit) begin
         if (seen_ff == SEEN_NONE) begin
            if (last_ff) begin
               push0 = 1'b1;
               res0  = '{center: raw_ff, frame_end: 1'b1};
            end else begin
               held_in = raw_ff;
               seen_in = SEEN_FIRST;
            end
         end else begin
            prior_in = cur;
            push0    = 1'b1;
            if (last_ff) begin
               push1   = 1'b1;
               seen_in = SEEN_NONE;
            end else begin
               held_in = raw_ff;
               seen_in = SEEN_MID;
            end
         end
      end
   end

   always_comb begin
      jump_in = jump_ff;
      minr_in = minr_ff;
      if (csr_we) begin
         case (csr_index)
            REG_JUMP_LIMIT: jump_in = csr_wdata[JUMP_W-1:0];
            REG_MIN_RUN:    minr_in = csr_wdata[MINRUN_W-1:0];
            default:        jump_in = jump_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         jump_ff  <= JUMP_RESET;
         minr_ff  <= MINRUN_RESET;
         prior_ff <= '0;
         held_ff  <= '0;
         seen_ff  <= SEEN_NONE;
         done_ff  <= 1'b0;
      end else begin
         jump_ff  <= jump_in;
         minr_ff  <= minr_in;
         prior_ff <= prior_in;
         held_ff  <= held_in;
         seen_ff  <= seen_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff    <= row_in;
      j_ff      <= j_in;
      blk_ff    <= blk_in;
      run_ff    <= run_in;
      tot_ff    <= tot_in;
      wht_ff    <= wht_in;
      whites_ff <= whites_in;
      bfirst_ff <= bfirst_in;
      last_ff   <= last_in;
      raw_ff    <= raw_in;
   end

endmodule

// ----- src/tce_outq.sv -----
module tce_outq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push0,
   input  logic                                push1,
   input  tce_pkg::tce_result_type             res0,
   input  tce_pkg::tce_result_type             res1,
   output logic                                empty,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [tce_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast
);
   import tce_pkg::*;

   tce_result_type head_ff, head_in;
   tce_result_type tail_ff, tail_in;
   logic [1:0]     count_ff, count_in;
   logic           pop;

   assign pop        = rsp_tvalid && rsp_tready;
   assign empty      = (count_ff == 2'd0);
   assign rsp_tvalid = !empty;
   assign rsp_tdata  = RSP_TDATA_W'(head_ff.center);
   assign rsp_tlast  = head_ff.frame_end;

   // pushes arrive only into an empty queue
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (pop) begin
         head_in  = tail_ff;
         count_in = count_ff - 1'b1;
      end else if (push0) begin
         head_in  = res0;
         tail_in  = res1;
         count_in = push1 ? 2'd2 : 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

// ----- src/track_center_extractor.sv -----
// Track center extractor.
// Input channel req_*: one image row per item, bit k of req_tdata is pixel k
// (1 black, 0 white); req_tlast marks the final row of a frame.
// Result channel rsp_*: one corrected center per row in rsp_tdata[5:0];
// rsp_tlast marks the result for the frame's last row. A row's center leaves
// when the following row has been scanned, since correction looks at the next
// raw center; a last row releases two results at once (one in a one-row frame).
// Configuration: csr_we with csr_index 0 writes jump_limit, index 1 min_run.
// Sequence: an item is accepted, then the pixel scan runs at one pixel per
// cycle (a black-first restart re-visits pixels), then the scan end is seen,
// the raw center is computed and the commit follows; results are valid the
// cycle after the commit. A new row is accepted only after the previous commit.
// req_tready is high only while the block waits for a row.
// Results go into a two-entry output queue; a new row is accepted and scanned
// while earlier results still wait there. When the receiver stalls, the
// commit holds until the queue has drained, and req_tready stays low meanwhile.
// Reset clears the queue, the held row and the registers to their defaults.
module track_center_extractor #(
   parameter int ROW_WIDTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // row_pixels
   input  logic [((ROW_WIDTH + 7) / 8) * 8-1:0] req_tdata,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // center, zero padded to a byte
   output logic [tce_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [tce_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [tce_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import tce_pkg::*;

   localparam int TDATA_W = ((ROW_WIDTH + 7) / 8) * 8;

   tce_cmd_type    cmd;
   tce_status_type status;
   tce_result_type res0, res1;
   logic           scan_done, queue_empty;
   logic           push0, push1;

   // controller sees only the scan-done and queue-empty status
   assign status.scan_done   = scan_done;
   assign status.queue_empty = queue_empty;

   tce_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   tce_dp #(
      .ROW_WIDTH (ROW_WIDTH),
      .TDATA_W   (TDATA_W)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .scan_done (scan_done),
      .push0     (push0),
      .push1     (push1),
      .res0      (res0),
      .res1      (res1)
   );

   tce_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push0      (push0),
      .push1      (push1),
      .res0       (res0),
      .res1       (res1),
      .empty      (queue_empty),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ----- src/tce_checker.sv -----
module tce_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [tce_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);
   import tce_pkg::*;

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result item changed");

   // req_tready is low in the cycle after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input item accepted back to back");

   // center never exceeds six bits
   a_center_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_TDATA_W-1:CENTER_W] == '0)
      else $error("result padding bits set");

   // reset empties the output queue
   a_reset_flush: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result item visible after reset");

endmodule

bind track_center_extractor tce_checker u_tce_checker (.*);
